@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define PTC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pressure compensation assertion failed");

// Next-cycle implication.
`define PTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pressure compensation assertion failed");

`else

`define PTC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define PTC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ sv/ptc_pkg.sv @@
package ptc_pkg;

  localparam int unsigned RAW_W   = 24;
  localparam int unsigned CAL_W   = 16;
  localparam int unsigned TEMP_W  = 19;
  localparam int unsigned PRES_W  = 26;
  localparam int unsigned DEPTH_W = 15;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic signed [19:0] TEMP_REF          = 20'sd2000;
  localparam logic [16:0]        SENS_BIAS         = 17'd30000;
  localparam logic [15:0]        DEPTH_SCALE_RESET = 16'd6703;
  localparam logic signed [19:0] TEMP_HI           = 20'sd200000;
  localparam logic signed [19:0] TEMP_LO           = -20'sd200000;
  localparam logic [14:0]        DEPTH_MAX         = 15'h7fff;
  localparam logic [42:0]        DEPTH_ROUND       = 43'd32768;

  typedef enum logic [2:0] {
    REG_CAL_SENS          = 3'd0,
    REG_CAL_OFFSET        = 3'd1,
    REG_CAL_SENS_TEMPCO   = 3'd2,
    REG_CAL_OFFSET_TEMPCO = 3'd3,
    REG_CAL_TEMP_REF      = 3'd4,
    REG_CAL_TEMP_SENS     = 3'd5,
    REG_ZERO_PRESSURE     = 3'd6,
    REG_DEPTH_SCALE       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        cal_sens;
    logic [15:0]        cal_offset;
    logic [15:0]        cal_sens_tempco;
    logic [15:0]        cal_offset_tempco;
    logic [15:0]        cal_temp_ref;
    logic [15:0]        cal_temp_sens;
    logic signed [25:0] zero_pressure;
    logic [15:0]        depth_scale;
  } cfg_t;

  // First-order coefficients handed to the compensation stages.
  typedef struct packed {
    logic [23:0]        raw_pressure;
    logic signed [18:0] temp_delta;   // (dT * cal_temp_sens) >> 23
    logic [17:0]        temp_corr;    // (9 * dT^2) >> 34
    logic signed [38:0] offset;
    logic signed [36:0] sens;
  } coef_t;

  typedef struct packed {
    logic signed [18:0] temperature;
    logic signed [25:0] pressure;
  } comp_t;

endpackage

@@ sv/pressure_temp_compensation_depth.sv @@
// Channel   Direction  Transfer                  Contents
// s_*       in         s_tvalid & s_tready       raw pressure and temperature pair
// m_*       out        m_tvalid & m_tready       temperature, pressure, depth_cm
// APB       in/out     psel&penable&pwrite       eight calibration registers
//
// One pair is taken per cycle while the output is not stalled; each result passes
// through the stages dT, products of dT, first-order terms, d^2 and split pressure
// product, second-order correction, pressure, depth scaling and rounding.
// Reset clears all stage valid bits and loads the register defaults.
// A stage holds while the next one is full and stalled; empty stages keep
// filling, so input is taken until every stage holds a waiting item.
`include "assert_macros.svh"

module pressure_temp_compensation_depth (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [18:0] temperature, [44:19] pressure,
                                 // [59:45] depth_cm, [63:60] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptc_pkg::*;

  cfg_t  cfg;
  coef_t coef;
  comp_t comp;
  comp_t result;
  logic  coef_valid, coef_ready;
  logic  comp_valid, comp_ready;
  logic [14:0] depth_cm;
  logic  temp_in_range;

  ptc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ptc_coef u_coef (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .raw_pressure    (s_tdata[23:0]),
    .raw_temperature (s_tdata[47:24]),
    .out_valid       (coef_valid),
    .out_ready       (coef_ready),
    .out_data        (coef)
  );

  ptc_comp u_comp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coef_valid),
    .in_ready  (coef_ready),
    .in_data   (coef),
    .out_valid (comp_valid),
    .out_ready (comp_ready),
    .out_data  (comp)
  );

  ptc_depth u_depth (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (comp_valid),
    .in_ready  (comp_ready),
    .in_data   (comp),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result),
    .depth_cm  (depth_cm)
  );

  assign m_tdata = {4'h0, depth_cm, result.pressure, result.temperature};

  assign temp_in_range = ($signed(result.temperature) <= $signed(TEMP_HI[18:0]))
                      && ($signed(result.temperature) >= $signed(TEMP_LO[18:0]));

  // Input is refused only when the whole pipeline backs up behind a stalled output.
  `PTC_ASSERT_IMPLY(a_ready_only_blocked_by_output, clk, rst, !s_tready, m_tvalid && !m_tready)
  // The first cycle after reset never shows a result.
  `PTC_ASSERT_IMPLY(a_empty_after_reset, clk, 1'b0, $fell(rst), !m_tvalid)
  // A shown temperature has been saturated to the legal range.
  `PTC_ASSERT_IMPLY(a_temp_in_range, clk, rst, m_tvalid, temp_in_range)

endmodule

@@ sv/ptc_cfg.sv @@
module ptc_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output ptc_pkg::cfg_t        cfg
);
  import ptc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_sens          <= '0;
      cfg.cal_offset        <= '0;
      cfg.cal_sens_tempco   <= '0;
      cfg.cal_offset_tempco <= '0;
      cfg.cal_temp_ref      <= '0;
      cfg.cal_temp_sens     <= '0;
      cfg.zero_pressure     <= '0;
      cfg.depth_scale       <= DEPTH_SCALE_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_CAL_SENS:          cfg.cal_sens          <= pwdata[15:0];
        REG_CAL_OFFSET:        cfg.cal_offset        <= pwdata[15:0];
        REG_CAL_SENS_TEMPCO:   cfg.cal_sens_tempco   <= pwdata[15:0];
        REG_CAL_OFFSET_TEMPCO: cfg.cal_offset_tempco <= pwdata[15:0];
        REG_CAL_TEMP_REF:      cfg.cal_temp_ref      <= pwdata[15:0];
        REG_CAL_TEMP_SENS:     cfg.cal_temp_sens     <= pwdata[15:0];
        REG_ZERO_PRESSURE:     cfg.zero_pressure     <= $signed(pwdata[25:0]);
        REG_DEPTH_SCALE:       cfg.depth_scale       <= pwdata[15:0];
        default:               cfg.depth_scale       <= cfg.depth_scale;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAL_SENS:          prdata = {16'h0000, cfg.cal_sens};
      REG_CAL_OFFSET:        prdata = {16'h0000, cfg.cal_offset};
      REG_CAL_SENS_TEMPCO:   prdata = {16'h0000, cfg.cal_sens_tempco};
      REG_CAL_OFFSET_TEMPCO: prdata = {16'h0000, cfg.cal_offset_tempco};
      REG_CAL_TEMP_REF:      prdata = {16'h0000, cfg.cal_temp_ref};
      REG_CAL_TEMP_SENS:     prdata = {16'h0000, cfg.cal_temp_sens};
      REG_ZERO_PRESSURE:     prdata = {{6{cfg.zero_pressure[25]}}, cfg.zero_pressure};
      REG_DEPTH_SCALE:       prdata = {16'h0000, cfg.depth_scale};
      default:               prdata = '0;
    endcase
  end

endmodule

@@ sv/ptc_coef.sv @@
module ptc_coef (
  input  logic           clk,
  input  logic           rst,
  input  ptc_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [23:0]    raw_pressure,
  input  logic [23:0]    raw_temperature,
  output logic           out_valid,
  input  logic           out_ready,
  output ptc_pkg::coef_t out_data
);
  import ptc_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;

  // Stage 1: dT.
  logic signed [24:0] dt_next;
  logic signed [24:0] dt;
  logic [23:0]        d1_s1;

  // Stage 2: the four products of dT.
  logic signed [41:0] prod_temp_next, prod_off_next, prod_sens_next;
  logic signed [49:0] dt_sq_next;
  logic signed [41:0] prod_temp, prod_off, prod_sens;
  logic [47:0]        dt_sq;
  logic [23:0]        d1_s2;

  // Stage 3: first-order terms.
  logic [16:0]        sens_base;
  logic [51:0]        dt_sq_x9;
  coef_t              coef_next;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.cal_temp_ref, 8'h00});

  always_ff @(posedge clk) begin
    if (en1) begin
      dt    <= dt_next;
      d1_s1 <= raw_pressure;
    end
  end

  assign prod_temp_next = dt * $signed({1'b0, cfg.cal_temp_sens});
  assign prod_off_next  = dt * $signed({1'b0, cfg.cal_offset_tempco});
  assign prod_sens_next = dt * $signed({1'b0, cfg.cal_sens_tempco});
  assign dt_sq_next     = dt * dt;

  always_ff @(posedge clk) begin
    if (en2) begin
      prod_temp <= prod_temp_next;
      prod_off  <= prod_off_next;
      prod_sens <= prod_sens_next;
      dt_sq     <= dt_sq_next[47:0];
      d1_s2     <= d1_s1;
    end
  end

  // Taking the upper bits of a signed value is the floor shift.
  assign sens_base = {1'b0, cfg.cal_sens} + SENS_BIAS;
  assign dt_sq_x9  = {1'b0, dt_sq, 3'b000} + {4'b0000, dt_sq};

  always_comb begin
    coef_next.raw_pressure = d1_s2;
    coef_next.temp_delta   = prod_temp[41:23];
    coef_next.temp_corr    = dt_sq_x9[51:34];
    coef_next.offset       = $signed({4'b0000, cfg.cal_offset, 19'h00000})
                           + $signed(prod_off[41:4]);
    coef_next.sens         = $signed({3'b000, sens_base, 17'h00000})
                           + $signed(prod_sens[41:6]);
  end

  always_ff @(posedge clk) begin
    if (en3) out_data <= coef_next;
  end

endmodule

@@ sv/ptc_comp.sv @@
module ptc_comp (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptc_pkg::coef_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ptc_pkg::comp_t out_data
);
  import ptc_pkg::*;

  logic v4, v5, v6;
  logic en4, en5, en6;

  // Stage 4: d^2 and the two halves of raw_pressure * SENS.
  logic signed [37:0] d_sq_next;
  logic [41:0]        prod_lo_next;
  logic signed [43:0] prod_hi_next;
  logic [34:0]        d_sq;
  logic [41:0]        prod_lo;
  logic signed [43:0] prod_hi;
  logic signed [18:0] temp_delta;
  logic [17:0]        temp_corr;
  logic signed [38:0] offset1;
  logic               cold;

  // Stage 5: second-order correction and product recombination.
  // The sensitivity correction (2*d^2) >> 38 is always zero because |d| <= 2^18.
  logic [18:0]        off_corr;
  logic signed [61:0] prod_next;
  logic signed [38:0] offset_next;
  logic signed [19:0] temp_next;
  logic signed [61:0] prod;
  logic signed [38:0] offset2;
  logic signed [19:0] temp2;

  // Stage 6: pressure and saturation.
  logic signed [41:0] p_diff;
  logic signed [26:0] p_wide;
  comp_t              comp_next;

  assign en6       = !v6 || out_ready;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign in_ready  = en4;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= in_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  assign d_sq_next    = in_data.temp_delta * in_data.temp_delta;
  assign prod_lo_next = {18'h00000, in_data.raw_pressure} * {24'h000000, in_data.sens[17:0]};
  assign prod_hi_next = $signed({1'b0, in_data.raw_pressure}) * $signed(in_data.sens[36:18]);

  always_ff @(posedge clk) begin
    if (en4) begin
      d_sq       <= d_sq_next[34:0];
      prod_lo    <= prod_lo_next;
      prod_hi    <= prod_hi_next;
      temp_delta <= in_data.temp_delta;
      temp_corr  <= in_data.temp_corr;
      offset1    <= in_data.offset;
      cold       <= in_data.temp_delta[18];
    end
  end

  // Below 20.00 C the temperature delta is negative.
  assign off_corr    = cold ? d_sq[34:16] : 19'h00000;
  assign prod_next   = $signed({prod_hi, 18'h00000}) + $signed({20'h00000, prod_lo});
  assign offset_next = offset1 - $signed({20'h00000, off_corr});
  assign temp_next   = TEMP_REF + temp_delta
                     - (cold ? $signed({2'b00, temp_corr}) : 20'sd0);

  always_ff @(posedge clk) begin
    if (en5) begin
      prod    <= prod_next;
      offset2 <= offset_next;
      temp2   <= temp_next;
    end
  end

  assign p_diff = $signed(prod[61:21]) - offset2;
  assign p_wide = p_diff[41:15];

  always_comb begin
    if (p_wide > 27'sd33554431) begin
      comp_next.pressure = 26'sh1ffffff;
    end else if (p_wide < -27'sd33554432) begin
      comp_next.pressure = 26'sh2000000;
    end else begin
      comp_next.pressure = p_wide[25:0];
    end
    if (temp2 > TEMP_HI) begin
      comp_next.temperature = TEMP_HI[18:0];
    end else if (temp2 < TEMP_LO) begin
      comp_next.temperature = TEMP_LO[18:0];
    end else begin
      comp_next.temperature = temp2[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en6) out_data <= comp_next;
  end

endmodule

@@ sv/ptc_depth.sv @@
module ptc_depth (
  input  logic           clk,
  input  logic           rst,
  input  ptc_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  ptc_pkg::comp_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ptc_pkg::comp_t out_data,
  output logic [14:0]    depth_cm
);
  import ptc_pkg::*;

  logic v7, v8;
  logic en7, en8;

  // Stage 7: clamp at the zero reference and scale.
  logic signed [26:0] delta;
  logic [25:0]        delta_pos;
  logic [41:0]        scaled_next;
  logic [41:0]        scaled;
  comp_t              comp_s7;

  // Stage 8: round and saturate into the output register.
  logic [42:0]        rounded;
  logic [14:0]        depth_next;

  assign en8       = !v8 || out_ready;
  assign en7       = !v7 || en8;
  assign in_ready  = en7;
  assign out_valid = v8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (en7) v7 <= in_valid;
      if (en8) v8 <= v7;
    end
  end

  assign delta       = $signed({in_data.pressure[25], in_data.pressure})
                     - $signed({cfg.zero_pressure[25], cfg.zero_pressure});
  assign delta_pos   = delta[26] ? 26'h0000000 : delta[25:0];
  assign scaled_next = {16'h0000, delta_pos} * {26'h0000000, cfg.depth_scale};

  always_ff @(posedge clk) begin
    if (en7) begin
      scaled  <= scaled_next;
      comp_s7 <= in_data;
    end
  end

  assign rounded    = {1'b0, scaled} + DEPTH_ROUND;
  assign depth_next = (|rounded[42:31]) ? DEPTH_MAX : rounded[30:16];

  always_ff @(posedge clk) begin
    if (en8) begin
      depth_cm <= depth_next;
      out_data <= comp_s7;
    end
  end

endmodule
